// File: hw/rtl/gbn_pkg.sv
`timescale 1ns / 1ps

package gbn_pkg;

  localparam int unsigned WINDOW_DEF        = 4;
  localparam int unsigned PENDING_DEPTH_DEF = 16;

  localparam int unsigned SEQ_W = 32;
  localparam int unsigned LEN_W = 12;
  localparam int unsigned RES_W = 4;
  localparam int unsigned NIB_COUNT = SEQ_W / 4;
  localparam int unsigned TBL_N = 128;

  localparam logic [1:0] ACT_SEND    = 2'd0;
  localparam logic [1:0] ACT_RECV    = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_NAK  = 2'd2;

  typedef logic [RES_W-1:0] res_t;
  typedef res_t res_tbl_t [TBL_N];

  typedef enum logic [1:0] {
    OP_SEND,
    OP_RECV,
    OP_TIMEOUT
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [1:0]        kind;
    logic [SEQ_W-1:0]  number;
    logic [SEQ_W-1:0]  handle;
    logic [LEN_W-1:0]  length;
    res_t              res;
  } cmd_t;

  typedef struct packed {
    logic [SEQ_W-1:0] handle;
    logic [LEN_W-1:0] length;
    res_t             res;
  } pend_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN_RD,
    ST_DRAIN_EMIT,
    ST_RETX
  } bk_state_e;

endpackage

// File: hw/rtl/gbn_front.sv
`timescale 1ns / 1ps

module gbn_front #(
  parameter int unsigned WINDOW = gbn_pkg::WINDOW_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 action_i,
  input  logic [1:0]                 frame_kind_i,
  input  logic [gbn_pkg::SEQ_W-1:0]  seq_number_i,
  input  logic [gbn_pkg::SEQ_W-1:0]  ack_number_i,
  input  logic [gbn_pkg::SEQ_W-1:0]  frame_handle_i,
  input  logic [gbn_pkg::LEN_W-1:0]  frame_length_i,
  output logic                       q_push_o,
  output gbn_pkg::cmd_t              q_data_o,
  input  logic                       q_full_i
);

  function automatic gbn_pkg::res_tbl_t build_nib();
    gbn_pkg::res_tbl_t t;
    int unsigned       p;
    p = 1 % WINDOW;
    for (int j = 0; j < gbn_pkg::NIB_COUNT; j++) begin
      for (int n = 0; n < 16; n++) begin
        t[j*16+n] = gbn_pkg::res_t'((n * p) % WINDOW);
      end
      p = (p * 16) % WINDOW;
    end
    return t;
  endfunction

  function automatic gbn_pkg::res_tbl_t build_red();
    gbn_pkg::res_tbl_t t;
    for (int s = 0; s < gbn_pkg::TBL_N; s++) begin
      t[s] = gbn_pkg::res_t'(s % WINDOW);
    end
    return t;
  endfunction

  localparam gbn_pkg::res_tbl_t NIB_TBL = build_nib();
  localparam gbn_pkg::res_tbl_t RED_TBL = build_red();

  logic                       valid_q, valid_d;
  gbn_pkg::cmd_t              cmd_q, cmd_d;
  logic [gbn_pkg::SEQ_W-1:0]  operand;
  logic [6:0]                 res_sum;
  logic                       known;
  gbn_pkg::op_e               op;

  assign in_stall_o = valid_q && q_full_i;
  assign q_push_o   = valid_q && !q_full_i;
  assign q_data_o   = cmd_q;

  assign operand = (action_i == gbn_pkg::ACT_SEND) ? seq_number_i : ack_number_i;

  always_comb begin
    res_sum = '0;
    for (int j = 0; j < gbn_pkg::NIB_COUNT; j++) begin
      res_sum = res_sum + 7'(NIB_TBL[{3'(j), operand[j*4 +: 4]}]);
    end
  end

  always_comb begin
    known = 1'b1;
    op    = gbn_pkg::OP_SEND;
    case (action_i)
      gbn_pkg::ACT_SEND:    op = gbn_pkg::OP_SEND;
      gbn_pkg::ACT_RECV:    op = gbn_pkg::OP_RECV;
      gbn_pkg::ACT_TIMEOUT: op = gbn_pkg::OP_TIMEOUT;
      default:              known = 1'b0;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (!in_stall_o) begin
      valid_d      = in_valid_i && known;
      cmd_d.op     = op;
      cmd_d.kind   = frame_kind_i;
      cmd_d.number = ack_number_i;
      cmd_d.handle = frame_handle_i;
      cmd_d.length = frame_length_i;
      cmd_d.res    = RED_TBL[res_sum];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// File: hw/rtl/gbn_queue.sv
`timescale 1ns / 1ps

module gbn_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gbn_pkg::cmd_t data_i,
  output logic          full_o,
  output logic          valid_o,
  output gbn_pkg::cmd_t data_o,
  input  logic          pop_i
);

  gbn_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue written while full");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue count out of range");

  a_pop_push_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("queue count lost a transfer");

endmodule

// File: hw/rtl/gbn_back.sv
`timescale 1ns / 1ps

module gbn_back #(
  parameter int unsigned WINDOW        = gbn_pkg::WINDOW_DEF,
  parameter int unsigned PENDING_DEPTH = gbn_pkg::PENDING_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  gbn_pkg::cmd_t              q_data_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       transmit_o,
  output logic [gbn_pkg::SEQ_W-1:0]  tx_handle_o,
  output logic [gbn_pkg::LEN_W-1:0]  tx_length_o,
  output logic [gbn_pkg::SEQ_W-1:0]  tx_seq_o,
  output logic                       error_o,
  output logic                       last_o
);

  localparam int unsigned SW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW   = $clog2(WINDOW + 1);
  localparam int unsigned PW   = $clog2(PENDING_DEPTH);
  localparam int unsigned CNTW = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned QW   = gbn_pkg::SEQ_W;
  localparam int unsigned LW   = gbn_pkg::LEN_W;

  gbn_pkg::bk_state_e state_q, state_d;

  logic [QW-1:0]   low_q, low_d;
  logic [QW-1:0]   high_q, high_d;
  logic [SW-1:0]   low_res_q, low_res_d;
  logic [CNTW-1:0] pend_cnt_q, pend_cnt_d;
  logic [PW-1:0]   head_q, head_d;
  logic [PW-1:0]   tail_q, tail_d;
  logic [CW-1:0]   rt_left_q, rt_left_d;
  logic [SW-1:0]   rt_slot_q, rt_slot_d;
  logic [QW-1:0]   rt_seq_q, rt_seq_d;

  logic [QW-1:0]   slot_handle_q [WINDOW];
  logic [LW-1:0]   slot_length_q [WINDOW];
  gbn_pkg::pend_t  pend_mem [PENDING_DEPTH];
  gbn_pkg::pend_t  pend_rd_q;

  logic            slot_we;
  logic [SW-1:0]   slot_widx;
  logic [QW-1:0]   slot_whandle;
  logic [LW-1:0]   slot_wlength;
  logic            pend_we;
  gbn_pkg::pend_t  pend_wdata;

  logic            out_valid_q, out_valid_d;
  logic            tx_q, tx_d;
  logic [QW-1:0]   handle_q, handle_d;
  logic [LW-1:0]   length_q, length_d;
  logic [QW-1:0]   seq_q, seq_d;
  logic            err_q, err_d;
  logic            last_q, last_d;
  logic            emit;

  gbn_pkg::cmd_t   cmd;
  logic [QW-1:0]   span;
  logic [QW-1:0]   off;
  logic            win_room;
  logic            in_win;
  logic            pend_full;
  logic            out_free;
  logic            needs_emit;
  logic            idle_act;
  logic            retx_go;
  logic [CW-1:0]   rt_cnt;
  logic            drain_go;
  logic            drain_last;

  assign cmd        = q_data_i;
  assign span       = high_q - low_q;
  assign off        = cmd.number - low_q;
  assign win_room   = span < QW'(WINDOW);
  assign in_win     = (off != '0) && (off <= span);
  assign pend_full  = pend_cnt_q == CNTW'(PENDING_DEPTH);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign rt_cnt     = (span > QW'(WINDOW)) ? CW'(WINDOW) : span[CW-1:0];
  assign drain_go   = (pend_cnt_q != '0) && win_room;
  assign drain_last = (pend_cnt_q == CNTW'(1)) || ((span + QW'(1)) >= QW'(WINDOW));

  always_comb begin
    needs_emit = 1'b0;
    retx_go    = 1'b0;
    case (cmd.op)
      gbn_pkg::OP_SEND: needs_emit = win_room || pend_full;
      gbn_pkg::OP_RECV: begin
        needs_emit = !in_win;
        retx_go    = in_win && (cmd.kind == gbn_pkg::KIND_NAK) && (rt_cnt != '0);
      end
      gbn_pkg::OP_TIMEOUT: retx_go = rt_cnt != '0;
      default: needs_emit = 1'b0;
    endcase
  end

  assign idle_act = (state_q == gbn_pkg::ST_IDLE) && q_valid_i && (out_free || !needs_emit);
  assign q_pop_o  = idle_act;

  always_comb begin
    state_d = state_q;
    case (state_q)
      gbn_pkg::ST_IDLE: begin
        if (idle_act) begin
          if (cmd.op == gbn_pkg::OP_RECV && in_win && cmd.kind == gbn_pkg::KIND_ACK) begin
            state_d = gbn_pkg::ST_DRAIN_RD;
          end else if (retx_go) begin
            state_d = gbn_pkg::ST_RETX;
          end
        end
      end
      gbn_pkg::ST_DRAIN_RD: begin
        state_d = drain_go ? gbn_pkg::ST_DRAIN_EMIT : gbn_pkg::ST_IDLE;
      end
      gbn_pkg::ST_DRAIN_EMIT: begin
        if (out_free) begin
          state_d = drain_last ? gbn_pkg::ST_IDLE : gbn_pkg::ST_DRAIN_RD;
        end
      end
      gbn_pkg::ST_RETX: begin
        if (out_free && rt_left_q == CW'(1)) begin
          state_d = gbn_pkg::ST_IDLE;
        end
      end
      default: state_d = gbn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    low_d        = low_q;
    high_d       = high_q;
    low_res_d    = low_res_q;
    pend_cnt_d   = pend_cnt_q;
    head_d       = head_q;
    tail_d       = tail_q;
    rt_left_d    = rt_left_q;
    rt_slot_d    = rt_slot_q;
    rt_seq_d     = rt_seq_q;
    slot_we      = 1'b0;
    slot_widx    = cmd.res[SW-1:0];
    slot_whandle = cmd.handle;
    slot_wlength = cmd.length;
    pend_we      = 1'b0;
    pend_wdata   = '{handle: cmd.handle, length: cmd.length, res: cmd.res};
    emit         = 1'b0;
    tx_d         = 1'b0;
    handle_d     = '0;
    length_d     = '0;
    seq_d        = '0;
    err_d        = 1'b0;
    last_d       = 1'b1;
    case (state_q)
      gbn_pkg::ST_IDLE: begin
        if (idle_act) begin
          case (cmd.op)
            gbn_pkg::OP_SEND: begin
              if (win_room) begin
                slot_we  = 1'b1;
                high_d   = high_q + QW'(1);
                emit     = 1'b1;
                tx_d     = 1'b1;
                handle_d = cmd.handle;
                length_d = cmd.length;
                seq_d    = high_q + QW'(1);
              end else if (pend_full) begin
                emit  = 1'b1;
                err_d = 1'b1;
              end else begin
                pend_we    = 1'b1;
                pend_cnt_d = pend_cnt_q + CNTW'(1);
                tail_d     = (tail_q == PW'(PENDING_DEPTH - 1)) ? '0 : tail_q + PW'(1);
              end
            end
            gbn_pkg::OP_RECV: begin
              if (!in_win) begin
                emit  = 1'b1;
                err_d = 1'b1;
              end else if (cmd.kind == gbn_pkg::KIND_ACK) begin
                low_d     = cmd.number;
                low_res_d = cmd.res[SW-1:0];
              end
            end
            default: ;
          endcase
          if (retx_go) begin
            rt_left_d = rt_cnt;
            rt_slot_d = (low_res_q == SW'(WINDOW - 1)) ? '0 : low_res_q + SW'(1);
            rt_seq_d  = low_q + QW'(1);
          end
        end
      end
      gbn_pkg::ST_DRAIN_EMIT: begin
        if (out_free) begin
          slot_we      = 1'b1;
          slot_widx    = pend_rd_q.res[SW-1:0];
          slot_whandle = pend_rd_q.handle;
          slot_wlength = pend_rd_q.length;
          high_d       = high_q + QW'(1);
          pend_cnt_d   = pend_cnt_q - CNTW'(1);
          head_d       = (head_q == PW'(PENDING_DEPTH - 1)) ? '0 : head_q + PW'(1);
          emit         = 1'b1;
          tx_d         = 1'b1;
          handle_d     = pend_rd_q.handle;
          length_d     = pend_rd_q.length;
          seq_d        = high_q + QW'(1);
          last_d       = drain_last;
        end
      end
      gbn_pkg::ST_RETX: begin
        if (out_free) begin
          emit      = 1'b1;
          tx_d      = 1'b1;
          handle_d  = slot_handle_q[rt_slot_q];
          length_d  = slot_length_q[rt_slot_q];
          seq_d     = rt_seq_q;
          last_d    = rt_left_q == CW'(1);
          rt_left_d = rt_left_q - CW'(1);
          rt_slot_d = (rt_slot_q == SW'(WINDOW - 1)) ? '0 : rt_slot_q + SW'(1);
          rt_seq_d  = rt_seq_q + QW'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbn_pkg::ST_IDLE;
      low_q       <= '0;
      high_q      <= '0;
      low_res_q   <= '0;
      pend_cnt_q  <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      rt_left_q   <= '0;
      rt_slot_q   <= '0;
      rt_seq_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      low_q       <= low_d;
      high_q      <= high_d;
      low_res_q   <= low_res_d;
      pend_cnt_q  <= pend_cnt_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      rt_left_q   <= rt_left_d;
      rt_slot_q   <= rt_slot_d;
      rt_seq_q    <= rt_seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      tx_q     <= tx_d;
      handle_q <= handle_d;
      length_q <= length_d;
      seq_q    <= seq_d;
      err_q    <= err_d;
      last_q   <= last_d;
    end
    if (slot_we) begin
      slot_handle_q[slot_widx] <= slot_whandle;
      slot_length_q[slot_widx] <= slot_wlength;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_mem[tail_q] <= pend_wdata;
    end
    pend_rd_q <= pend_mem[head_q];
  end

  assign out_valid_o = out_valid_q;
  assign transmit_o  = tx_q;
  assign tx_handle_o = handle_q;
  assign tx_length_o = length_q;
  assign tx_seq_o    = seq_q;
  assign error_o     = err_q;
  assign last_o      = last_q;

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q <= CNTW'(PENDING_DEPTH))
    else $error("pending count above depth");

  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (high_q - low_q) <= QW'(WINDOW))
    else $error("outstanding frames above window");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_cnt_q == '0) |-> (head_q == tail_q))
    else $error("pending pointers disagree on empty queue");

  a_retx_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbn_pkg::ST_RETX) |-> (rt_left_q != '0))
    else $error("retransmission with nothing left");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !emit)
    else $error("result overwritten while stalled");

endmodule

// File: hw/rtl/go_back_n_arq_sender.sv
`timescale 1ns / 1ps

// Go-back-N sender window.
// Input channel (in_valid_i / in_stall_o): one request per transfer; action
// selects send request, received frame or timeout. Output channel
// (out_valid_o / out_stall_i): one result per transmission or error, with
// last_o set on the final result of a request. Requests that cause no result
// produce nothing on the output.
// A request passes a register stage that decodes it and reduces the sequence
// or ack number modulo WINDOW, then a two-entry queue, then the window
// sequencer. A send, a queued send or an error is handled in the idle state
// alone; a nak or timeout then stays in RETX while it resends its frames
// (up to WINDOW), and an ack alternates DRAIN_RD and DRAIN_EMIT for each
// drained frame, or visits DRAIN_RD alone when none drains; each drained
// frame pays one registered read of the pending memory. The front accepts
// one request a cycle until the queue fills. Reset empties the window, the
// pending queue and the output register; the block accepts requests as
// soon as reset is released. A stalled output holds its result and the
// sequencer waits on requests that produce a result; requests keep
// entering until the queue and the front register are full, then
// in_stall_o rises.

module go_back_n_arq_sender #(
  parameter int unsigned WINDOW        = gbn_pkg::WINDOW_DEF,
  parameter int unsigned PENDING_DEPTH = gbn_pkg::PENDING_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 action_i,
  input  logic [1:0]                 frame_kind_i,
  input  logic [gbn_pkg::SEQ_W-1:0]  seq_number_i,
  input  logic [gbn_pkg::SEQ_W-1:0]  ack_number_i,
  input  logic [gbn_pkg::SEQ_W-1:0]  frame_handle_i,
  input  logic [gbn_pkg::LEN_W-1:0]  frame_length_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       transmit_o,
  output logic [gbn_pkg::SEQ_W-1:0]  tx_handle_o,
  output logic [gbn_pkg::LEN_W-1:0]  tx_length_o,
  output logic [gbn_pkg::SEQ_W-1:0]  tx_seq_o,
  output logic                       error_o,
  output logic                       last_o
);

  logic          push;
  gbn_pkg::cmd_t push_data;
  logic          q_full;
  logic          q_valid;
  gbn_pkg::cmd_t q_data;
  logic          q_pop;

  gbn_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .frame_kind_i   (frame_kind_i),
    .seq_number_i   (seq_number_i),
    .ack_number_i   (ack_number_i),
    .frame_handle_i (frame_handle_i),
    .frame_length_i (frame_length_i),
    .q_push_o       (push),
    .q_data_o       (push_data),
    .q_full_i       (q_full)
  );

  gbn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  gbn_back #(
    .WINDOW        (WINDOW),
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .transmit_o  (transmit_o),
    .tx_handle_o (tx_handle_o),
    .tx_length_o (tx_length_o),
    .tx_seq_o    (tx_seq_o),
    .error_o     (error_o),
    .last_o      (last_o)
  );

endmodule
